FILE: rtl/core/pcf_pkg.sv
// Shared types and constants of the particle contact heat flux unit.
package pcf_pkg;

    // Configuration register indexes and widths
    localparam int CFG_IDX_W = 3;
    localparam int COND_W    = 31;
    localparam logic [CFG_IDX_W-1:0] REG_COND0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COND1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COND2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COND3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEWTON = 3'd4;

    // Pipeline step counts
    localparam int DIV_STEPS  = 64;
    localparam int H_STEPS    = 33;
    localparam int SQRT_STEPS = 32;

    // round(pi/4 * 2^32)
    localparam logic [31:0] PI4_Q32 = 32'd3373259426;

    localparam int FLUX_W = 48;
    localparam int HC_W   = 49;

    // Input word
    typedef struct packed {
        logic signed [31:0] del_x;
        logic signed [31:0] del_y;
        logic signed [31:0] del_z;
        logic [30:0]        radius_i;
        logic [30:0]        radius_j;
        logic [1:0]         type_i;
        logic [1:0]         type_j;
        logic signed [31:0] temp_i;
        logic signed [31:0] temp_j;
        logic signed [31:0] source_i;
        logic signed [31:0] source_j;
        logic               j_is_local;
    } pair_t;

    // Output word
    typedef struct packed {
        logic                     in_contact;
        logic signed [FLUX_W-1:0] flux_i;
        logic signed [FLUX_W-1:0] flux_j;
        logic                     flux_j_valid;
    } result_t;

    // Per-pair data that rides along with the arithmetic
    typedef struct packed {
        logic               jvalid;
        logic signed [32:0] dt;
        logic signed [31:0] src_i;
        logic signed [31:0] src_j;
    } side_t;

    // Front end to divider
    typedef struct packed {
        logic [63:0] n_hi;
        logic [63:0] n_lo;
        logic [63:0] d2;
        logic [61:0] kk;
        logic [31:0] ksum;
        logic        kzero;
        logic        contact;
        logic        area_ok;
        side_t       side;
    } front_t;

    // Divider to root stage
    typedef struct packed {
        logic [63:0] q;
        logic [32:0] h;
        logic        kzero;
        logic        contact;
        logic        area_ok;
        side_t       side;
    } quot_t;

    // Root stage to flux stage
    typedef struct packed {
        logic [HC_W-1:0] hc;
        logic            contact;
        side_t           side;
    } cond_t;

endpackage

FILE: rtl/core/particle_contact_heat_flux_unit.sv
// Top level of the particle contact heat flux unit.
//
// Takes one neighbor pair per clock while s_ready is high and returns one result word
// per pair, in order. The pipeline depth is set by the 64-stage radix-2 divider for
// the lens quotient and the 32-stage square root behind it; the conductivity divide
// runs inside the first 33 divider stages. The whole pipeline advances together; a
// two-word output buffer keeps s_ready high while one result waits on m_ready, and
// s_ready drops only when both buffer words are full.
// Conductivities and newton mode are plain registers sampled as a pair enters, so
// write them only while no pair is in flight. There is no memory and no clearing pass.
module particle_contact_heat_flux_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  pcf_pkg::pair_t                    s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output pcf_pkg::result_t                  m_data,
    input  logic                              cfg_wr_en,
    input  logic [pcf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcf_pkg::COND_W-1:0]        cfg_wdata
);

    logic [pcf_pkg::COND_W-1:0] cond0_reg, cond1_reg, cond2_reg, cond3_reg;
    logic                       newton_reg;
    logic [pcf_pkg::COND_W-1:0] ki, kj;
    logic                       en, acc, push, pop;

    logic             front_vld, div_vld, root_vld, flux_vld;
    pcf_pkg::front_t  front_data;
    pcf_pkg::quot_t   div_data;
    pcf_pkg::cond_t   root_data;
    pcf_pkg::result_t flux_data;

    logic             out_vld_reg, skid_vld_reg;
    pcf_pkg::result_t m_data_reg, skid_data_reg;

    function automatic logic [pcf_pkg::COND_W-1:0] pick_cond(
        input logic [1:0]                 t,
        input logic [pcf_pkg::COND_W-1:0] c0,
        input logic [pcf_pkg::COND_W-1:0] c1,
        input logic [pcf_pkg::COND_W-1:0] c2,
        input logic [pcf_pkg::COND_W-1:0] c3
    );
        logic [pcf_pkg::COND_W-1:0] r;
        unique case (t)
            2'd0: r = c0;
            2'd1: r = c1;
            2'd2: r = c2;
            2'd3: r = c3;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cond0_reg  <= '0;
            cond1_reg  <= '0;
            cond2_reg  <= '0;
            cond3_reg  <= '0;
            newton_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pcf_pkg::REG_COND0:  cond0_reg  <= cfg_wdata;
                pcf_pkg::REG_COND1:  cond1_reg  <= cfg_wdata;
                pcf_pkg::REG_COND2:  cond2_reg  <= cfg_wdata;
                pcf_pkg::REG_COND3:  cond3_reg  <= cfg_wdata;
                pcf_pkg::REG_NEWTON: newton_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Pipeline advances unless both output words are held
    assign en      = !(out_vld_reg && skid_vld_reg);
    assign s_ready = en;
    assign acc     = s_valid && en;
    assign push    = en && flux_vld;
    assign pop     = out_vld_reg && m_ready;

    assign ki = pick_cond(s_data.type_i, cond0_reg, cond1_reg, cond2_reg, cond3_reg);
    assign kj = pick_cond(s_data.type_j, cond0_reg, cond1_reg, cond2_reg, cond3_reg);

    pcf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (acc),
        .in_pair   (s_data),
        .ki        (ki),
        .kj        (kj),
        .jvalid    (newton_reg || s_data.j_is_local),
        .out_valid (front_vld),
        .out_data  (front_data)
    );

    pcf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_vld),
        .in_data   (front_data),
        .out_valid (div_vld),
        .out_data  (div_data)
    );

    pcf_root u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_vld),
        .in_data   (div_data),
        .out_valid (root_vld),
        .out_data  (root_data)
    );

    pcf_flux u_flux (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (root_vld),
        .in_data   (root_data),
        .out_valid (flux_vld),
        .out_data  (flux_data)
    );

    // Output buffer: head word plus one skid word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (pop) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (!out_vld_reg || pop) begin
            out_vld_reg <= push;
        end else if (push) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (pop) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (!out_vld_reg || pop) begin
            if (push) begin
                m_data_reg <= flux_data;
            end
        end else if (push) begin
            skid_data_reg <= flux_data;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/core/pcf_front.sv
// Front end: squares, contact test and the 128-bit lens numerator.
module pcf_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  pcf_pkg::pair_t      in_pair,
    input  logic [30:0]         ki,
    input  logic [30:0]         kj,
    input  logic                jvalid,
    output logic                out_valid,
    output pcf_pkg::front_t     out_data
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] vld_reg;

    // Stage A inputs
    logic signed [63:0] sqx, sqy, sqz;
    logic [31:0]        rs;
    logic [30:0]        rd;
    logic [63:0]        s2;
    logic [61:0]        dd2;
    logic [61:0]        kk;
    logic [31:0]        ksum;
    pcf_pkg::side_t     side_in;

    // Stage A
    logic [63:0]    sqx_a_reg, sqy_a_reg, sqz_a_reg, s2_a_reg, dd2_a_reg;
    logic [61:0]    kk_a_reg;
    logic [31:0]    ksum_a_reg;
    logic           kzero_a_reg;
    pcf_pkg::side_t side_a_reg;
    // Stage B
    logic [63:0]    d2_b_reg, s2_b_reg, dd2_b_reg;
    logic [61:0]    kk_b_reg;
    logic [31:0]    ksum_b_reg;
    logic           kzero_b_reg;
    pcf_pkg::side_t side_b_reg;
    // Stage C
    logic [63:0]    d2_c_reg, a_c_reg, b_c_reg;
    logic           contact_c_reg, area_ok_c_reg;
    logic [61:0]    kk_c_reg;
    logic [31:0]    ksum_c_reg;
    logic           kzero_c_reg;
    pcf_pkg::side_t side_c_reg;
    // Stage D
    logic [63:0]    p00_reg, p01_reg, p10_reg, p11_reg, d2_d_reg;
    logic           contact_d_reg, area_ok_d_reg;
    logic [61:0]    kk_d_reg;
    logic [31:0]    ksum_d_reg;
    logic           kzero_d_reg;
    pcf_pkg::side_t side_d_reg;
    // Stage E
    logic [127:0]   n_next;
    pcf_pkg::front_t out_reg;

    // Squares and radius terms
    assign sqx  = in_pair.del_x * in_pair.del_x;
    assign sqy  = in_pair.del_y * in_pair.del_y;
    assign sqz  = in_pair.del_z * in_pair.del_z;
    assign rs   = {1'b0, in_pair.radius_i} + {1'b0, in_pair.radius_j};
    assign rd   = (in_pair.radius_i > in_pair.radius_j) ?
                  (in_pair.radius_i - in_pair.radius_j) :
                  (in_pair.radius_j - in_pair.radius_i);
    assign s2   = rs * rs;
    assign dd2  = rd * rd;
    assign kk   = ki * kj;
    assign ksum = {1'b0, ki} + {1'b0, kj};

    always_comb begin
        side_in.jvalid = jvalid;
        side_in.dt     = {in_pair.temp_j[31], in_pair.temp_j}
                       - {in_pair.temp_i[31], in_pair.temp_i};
        side_in.src_i  = in_pair.source_i;
        side_in.src_j  = in_pair.source_j;
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // Combine partial products into the numerator
    assign n_next = {p11_reg, p00_reg} + {32'd0, p01_reg, 32'd0} + {32'd0, p10_reg, 32'd0};

    always_ff @(posedge aclk) begin
        if (en) begin
            // Stage A: multiply
            sqx_a_reg   <= sqx;
            sqy_a_reg   <= sqy;
            sqz_a_reg   <= sqz;
            s2_a_reg    <= s2;
            dd2_a_reg   <= {2'b00, dd2};
            kk_a_reg    <= kk;
            ksum_a_reg  <= ksum;
            kzero_a_reg <= (ki == '0) || (kj == '0);
            side_a_reg  <= side_in;
            // Stage B: squared distance
            d2_b_reg    <= sqx_a_reg + sqy_a_reg + sqz_a_reg;
            s2_b_reg    <= s2_a_reg;
            dd2_b_reg   <= dd2_a_reg;
            kk_b_reg    <= kk_a_reg;
            ksum_b_reg  <= ksum_a_reg;
            kzero_b_reg <= kzero_a_reg;
            side_b_reg  <= side_a_reg;
            // Stage C: compare and form the two factors
            d2_c_reg      <= d2_b_reg;
            a_c_reg       <= s2_b_reg - d2_b_reg;
            b_c_reg       <= d2_b_reg - dd2_b_reg;
            contact_c_reg <= d2_b_reg < s2_b_reg;
            area_ok_c_reg <= d2_b_reg > dd2_b_reg;
            kk_c_reg      <= kk_b_reg;
            ksum_c_reg    <= ksum_b_reg;
            kzero_c_reg   <= kzero_b_reg;
            side_c_reg    <= side_b_reg;
            // Stage D: partial products
            p00_reg       <= a_c_reg[31:0] * b_c_reg[31:0];
            p01_reg       <= a_c_reg[31:0] * b_c_reg[63:32];
            p10_reg       <= a_c_reg[63:32] * b_c_reg[31:0];
            p11_reg       <= a_c_reg[63:32] * b_c_reg[63:32];
            d2_d_reg      <= d2_c_reg;
            contact_d_reg <= contact_c_reg;
            area_ok_d_reg <= area_ok_c_reg;
            kk_d_reg      <= kk_c_reg;
            ksum_d_reg    <= ksum_c_reg;
            kzero_d_reg   <= kzero_c_reg;
            side_d_reg    <= side_c_reg;
            // Stage E: numerator
            out_reg.n_hi    <= n_next[127:64];
            out_reg.n_lo    <= n_next[63:0];
            out_reg.d2      <= d2_d_reg;
            out_reg.kk      <= kk_d_reg;
            out_reg.ksum    <= ksum_d_reg;
            out_reg.kzero   <= kzero_d_reg;
            out_reg.contact <= contact_d_reg;
            out_reg.area_ok <= area_ok_d_reg;
            out_reg.side    <= side_d_reg;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_data  = out_reg;

endmodule

FILE: rtl/core/pcf_div.sv
// Radix-2 divider pipeline: lens quotient and harmonic conductivity, one bit per stage.
module pcf_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  pcf_pkg::front_t  in_data,
    output logic             out_valid,
    output pcf_pkg::quot_t   out_data
);

    typedef struct packed {
        logic [63:0]    rem;
        logic [63:0]    lq;
        logic [63:0]    d;
        logic [31:0]    hrem;
        logic [32:0]    hlq;
        logic [31:0]    hd;
        logic           kzero;
        logic           contact;
        logic           area_ok;
        pcf_pkg::side_t side;
    } div_stage_t;

    div_stage_t                       stg_reg [pcf_pkg::DIV_STEPS];
    logic [pcf_pkg::DIV_STEPS-1:0]    vld_reg;
    div_stage_t                       init;

    // Load dividend and divisors; the conductivity dividend is 4*ki*kj
    always_comb begin
        init.rem     = in_data.n_hi;
        init.lq      = in_data.n_lo;
        init.d       = in_data.d2;
        init.hrem    = {1'b0, in_data.kk[61:31]};
        init.hlq     = {in_data.kk[30:0], 2'b00};
        init.hd      = in_data.ksum;
        init.kzero   = in_data.kzero;
        init.contact = in_data.contact;
        init.area_ok = in_data.area_ok;
        init.side    = in_data.side;
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[pcf_pkg::DIV_STEPS-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < pcf_pkg::DIV_STEPS; k++) begin : g_step
        div_stage_t  cur;
        div_stage_t  nxt;
        logic [64:0] shf;
        logic        ge;
        logic [32:0] hshf;
        logic        hge;

        if (k == 0) begin : g_first
            assign cur = init;
        end else begin : g_later
            assign cur = stg_reg[k-1];
        end

        // One restoring step; the conductivity divide runs in the first stages only
        always_comb begin
            nxt     = cur;
            shf     = {cur.rem, cur.lq[63]};
            ge      = shf[64] || (shf[63:0] >= cur.d);
            nxt.rem = ge ? (shf[63:0] - cur.d) : shf[63:0];
            nxt.lq  = {cur.lq[62:0], ge};
            hshf    = {cur.hrem, cur.hlq[32]};
            hge     = hshf[32] || (hshf[31:0] >= cur.hd);
            if (k < pcf_pkg::H_STEPS) begin
                nxt.hrem = hge ? (hshf[31:0] - cur.hd) : hshf[31:0];
                nxt.hlq  = {cur.hlq[31:0], hge};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stg_reg[k] <= nxt;
            end
        end
    end

    always_comb begin
        out_data.q       = stg_reg[pcf_pkg::DIV_STEPS-1].lq;
        out_data.h       = stg_reg[pcf_pkg::DIV_STEPS-1].hlq;
        out_data.kzero   = stg_reg[pcf_pkg::DIV_STEPS-1].kzero;
        out_data.contact = stg_reg[pcf_pkg::DIV_STEPS-1].contact;
        out_data.area_ok = stg_reg[pcf_pkg::DIV_STEPS-1].area_ok;
        out_data.side    = stg_reg[pcf_pkg::DIV_STEPS-1].side;
    end

    assign out_valid = vld_reg[pcf_pkg::DIV_STEPS-1];

endmodule

FILE: rtl/core/pcf_root.sv
// Contact area, pipelined square root and conductance.
module pcf_root (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  pcf_pkg::quot_t  in_data,
    output logic            out_valid,
    output pcf_pkg::cond_t  out_data
);

    typedef struct packed {
        logic [63:0]    v;
        logic [63:0]    res;
        logic [32:0]    h;
        logic           kzero;
        logic           contact;
        pcf_pkg::side_t side;
    } sq_stage_t;

    localparam int STAGES = pcf_pkg::SQRT_STEPS + 4;

    logic [STAGES-1:0] vld_reg;

    // Area product stage
    logic [63:0]    pl_reg, ph_reg;
    logic [32:0]    h_r_reg;
    logic           kzero_r_reg, contact_r_reg, area_ok_r_reg;
    pcf_pkg::side_t side_r_reg;
    logic [95:0]    area_sum;
    sq_stage_t      area_reg;
    sq_stage_t      sq_reg [pcf_pkg::SQRT_STEPS];
    // Conductance stages
    logic [64:0]    prod_reg;
    logic           contact_p_reg;
    pcf_pkg::side_t side_p_reg;
    pcf_pkg::cond_t out_reg;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    assign area_sum = {ph_reg, 32'd0} + {32'd0, pl_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            // Multiply the quotient by pi/4
            pl_reg        <= in_data.q[31:0] * pcf_pkg::PI4_Q32;
            ph_reg        <= in_data.q[63:32] * pcf_pkg::PI4_Q32;
            h_r_reg       <= in_data.h;
            kzero_r_reg   <= in_data.kzero;
            contact_r_reg <= in_data.contact;
            area_ok_r_reg <= in_data.area_ok;
            side_r_reg    <= in_data.side;
            // Drop the area when one sphere lies inside the other
            area_reg.v       <= area_ok_r_reg ? area_sum[95:32] : 64'd0;
            area_reg.res     <= 64'd0;
            area_reg.h       <= h_r_reg;
            area_reg.kzero   <= kzero_r_reg;
            area_reg.contact <= contact_r_reg;
            area_reg.side    <= side_r_reg;
        end
    end

    // Digit-by-digit square root, two radicand bits per stage
    for (genvar k = 0; k < pcf_pkg::SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (2 * (pcf_pkg::SQRT_STEPS - 1 - k));
        sq_stage_t   cur;
        sq_stage_t   nxt;
        logic [63:0] trial;

        if (k == 0) begin : g_first
            assign cur = area_reg;
        end else begin : g_later
            assign cur = sq_reg[k-1];
        end

        always_comb begin
            nxt   = cur;
            trial = cur.res + BIT;
            if (cur.v >= trial) begin
                nxt.v   = cur.v - trial;
                nxt.res = (cur.res >> 1) + BIT;
            end else begin
                nxt.res = cur.res >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_reg[k] <= nxt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Conductance: H * sqrt(area), zero when a conductivity is zero
            prod_reg      <= sq_reg[pcf_pkg::SQRT_STEPS-1].kzero ? 65'd0 :
                             sq_reg[pcf_pkg::SQRT_STEPS-1].h *
                             sq_reg[pcf_pkg::SQRT_STEPS-1].res[31:0];
            contact_p_reg <= sq_reg[pcf_pkg::SQRT_STEPS-1].contact;
            side_p_reg    <= sq_reg[pcf_pkg::SQRT_STEPS-1].side;
            out_reg.hc      <= prod_reg[64:16];
            out_reg.contact <= contact_p_reg;
            out_reg.side    <= side_p_reg;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_data  = out_reg;

endmodule

FILE: rtl/core/pcf_flux.sv
// Flux terms: temperature difference times conductance, plus source, saturated.
module pcf_flux (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  pcf_pkg::cond_t   in_data,
    output logic             out_valid,
    output pcf_pkg::result_t out_data
);

    localparam int STAGES = 4;
    localparam logic signed [50:0] SAT_MAX = 51'sd140737488355327;
    localparam logic signed [50:0] SAT_MIN = -51'sd140737488355328;
    localparam logic [48:0]        TERM_LIM = 49'd1 << 48;

    function automatic logic [pcf_pkg::FLUX_W-1:0] flux_sum(
        input logic [48:0]        m,
        input logic               neg,
        input logic signed [31:0] src
    );
        logic signed [50:0] t;
        logic signed [50:0] v;
        t = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
        v = t + {{19{src[31]}}, src};
        if (v > SAT_MAX) begin
            v = SAT_MAX;
        end else if (v < SAT_MIN) begin
            v = SAT_MIN;
        end
        return v[pcf_pkg::FLUX_W-1:0];
    endfunction

    logic [STAGES-1:0] vld_reg;

    logic [32:0]        mag_reg, mag_next;
    logic               negi_reg, negj_reg, negi1_reg, negj1_reg, negi2_reg, negj2_reg;
    logic [pcf_pkg::HC_W-1:0] hc_reg;
    logic               con_reg, con1_reg, con2_reg;
    logic               jv_reg, jv1_reg, jv2_reg;
    logic signed [31:0] si_reg, sj_reg, si1_reg, sj1_reg, si2_reg, sj2_reg;
    logic [57:0]        plo_reg;
    logic [56:0]        phi_reg;
    logic [81:0]        prod_next;
    logic [48:0]        m_reg;
    pcf_pkg::result_t   out_reg;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    assign mag_next  = in_data.side.dt[32] ? (33'd0 - in_data.side.dt) : in_data.side.dt;
    assign prod_next = {phi_reg, 25'd0} + {24'd0, plo_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            // Magnitude of the temperature difference; both terms share it
            mag_reg  <= mag_next;
            negi_reg <= in_data.side.dt[32];
            negj_reg <= !in_data.side.dt[32] && (in_data.side.dt != '0);
            hc_reg   <= in_data.hc;
            con_reg  <= in_data.contact;
            jv_reg   <= in_data.side.jvalid;
            si_reg   <= in_data.side.src_i;
            sj_reg   <= in_data.side.src_j;
            // Partial products
            plo_reg   <= mag_reg * hc_reg[24:0];
            phi_reg   <= mag_reg * hc_reg[48:25];
            negi1_reg <= negi_reg;
            negj1_reg <= negj_reg;
            con1_reg  <= con_reg;
            jv1_reg   <= jv_reg;
            si1_reg   <= si_reg;
            sj1_reg   <= sj_reg;
            // Truncate to Q.16 and limit the term
            m_reg     <= (prod_next[81:64] != '0) ? TERM_LIM : {1'b0, prod_next[63:16]};
            negi2_reg <= negi1_reg;
            negj2_reg <= negj1_reg;
            con2_reg  <= con1_reg;
            jv2_reg   <= jv1_reg;
            si2_reg   <= si1_reg;
            sj2_reg   <= sj1_reg;
            // Add sources, saturate and gate
            out_reg.in_contact   <= con2_reg;
            out_reg.flux_i       <= con2_reg ? flux_sum(m_reg, negi2_reg, si2_reg) : '0;
            out_reg.flux_j       <= (con2_reg && jv2_reg) ?
                                    flux_sum(m_reg, negj2_reg, sj2_reg) : '0;
            out_reg.flux_j_valid <= con2_reg && jv2_reg;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_data  = out_reg;

endmodule
